// ===== hw/rtl/upqe_pkg.sv =====
// shared types, constants and helpers for the url path/query escaper
`default_nettype none
package upqe_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChQmark   = 8'h3f;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChDash    = 8'h2d;
  localparam logic [7:0] ChUscore  = 8'h5f;

  typedef enum logic [1:0] {
    SecScheme = 2'd0,
    SecHost   = 2'd1,
    SecPath   = 2'd2,
    SecQuery  = 2'd3
  } section_e;

  typedef enum logic [1:0] {
    PhLead = 2'd0,
    PhHigh = 2'd1,
    PhLow  = 2'd2
  } phase_e;

  // one classified item: byte to send, whether it expands to %xx, end of url
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       fin;
  } upqe_cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/upqe_front.sv =====
// front end: tracks url section and classifies each incoming byte
`default_nettype none
module upqe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_end_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output upqe_pkg::upqe_cmd_t    cmd_o
);

  upqe_pkg::section_e section_q, section_d;
  logic [1:0]         match_q, match_d;
  logic               accept;
  logic               query_keep;
  logic [7:0]         sep_ch;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  assign sep_ch = (match_q == 2'd0) ? upqe_pkg::ChColon : upqe_pkg::ChSlash;

  always_comb begin
    query_keep = ((in_byte_i >= 8'h30) && (in_byte_i <= 8'h39)) ||
                 ((in_byte_i >= 8'h61) && (in_byte_i <= 8'h7a)) ||
                 ((in_byte_i >= 8'h41) && (in_byte_i <= 8'h5a)) ||
                 (in_byte_i == upqe_pkg::ChDot) || (in_byte_i == upqe_pkg::ChDash) ||
                 (in_byte_i == upqe_pkg::ChUscore);
  end

  always_comb begin
    section_d = section_q;
    match_d   = match_q;
    case (section_q)
      upqe_pkg::SecScheme: begin
        if (in_byte_i == sep_ch) begin
          if (match_q == 2'd2) begin
            section_d = upqe_pkg::SecHost;
            match_d   = 2'd0;
          end else begin
            match_d = match_q + 2'd1;
          end
        end else begin
          match_d = (in_byte_i == upqe_pkg::ChColon) ? 2'd1 : 2'd0;
        end
      end
      upqe_pkg::SecHost: begin
        if (in_byte_i == upqe_pkg::ChSlash) section_d = upqe_pkg::SecPath;
      end
      upqe_pkg::SecPath: begin
        if (in_byte_i == upqe_pkg::ChQmark) section_d = upqe_pkg::SecQuery;
      end
      default: begin
      end
    endcase
    // end of url returns to the scheme search
    if (in_end_i) begin
      section_d = upqe_pkg::SecScheme;
      match_d   = 2'd0;
    end
  end

  always_comb begin
    cmd_o.data = in_byte_i;
    cmd_o.esc  = 1'b0;
    cmd_o.fin  = in_end_i;
    case (section_q)
      upqe_pkg::SecPath: begin
        if (in_byte_i == upqe_pkg::ChSpace) cmd_o.esc = 1'b1;
      end
      upqe_pkg::SecQuery: begin
        if (in_byte_i == upqe_pkg::ChSpace) begin
          cmd_o.data = upqe_pkg::ChPlus;
        end else if (!query_keep) begin
          cmd_o.esc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q <= upqe_pkg::SecScheme;
      match_q   <= 2'd0;
    end else if (accept) begin
      section_q <= section_d;
      match_q   <= match_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/upqe_fifo.sv =====
// short command queue between front and back end
`default_nettype none
module upqe_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_valid_i,
  output logic                      wr_ready_o,
  input  wire upqe_pkg::upqe_cmd_t  wr_cmd_i,
  output logic                      rd_valid_o,
  input  wire logic                 rd_pop_i,
  output upqe_pkg::upqe_cmd_t       rd_cmd_o
);

  upqe_pkg::upqe_cmd_t               mem_q [upqe_pkg::FifoDepth];
  logic [upqe_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [upqe_pkg::FifoCntW-1:0]     count_q, count_d;
  logic                              push, pop;

  assign wr_ready_o = (count_q != upqe_pkg::FifoCntW'(upqe_pkg::FifoDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_pop_i & rd_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/upqe_back.sv =====
// back end: expands queued commands into output bytes behind an output register
`default_nettype none
module upqe_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire upqe_pkg::upqe_cmd_t  cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o,
  output logic                      out_done_o
);

  upqe_pkg::phase_e phase_q, phase_d;
  logic             valid_q;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             done_q;
  logic             load;

  assign load = cmd_valid_i & (~valid_q | out_ready_i);

  always_comb begin
    phase_d = upqe_pkg::PhLead;
    if (cmd_i.esc) begin
      case (phase_q)
        upqe_pkg::PhLead: phase_d = upqe_pkg::PhHigh;
        upqe_pkg::PhHigh: phase_d = upqe_pkg::PhLow;
        default:          phase_d = upqe_pkg::PhLead;
      endcase
    end
  end

  always_comb begin
    byte_d = cmd_i.data;
    last_d = 1'b1;
    if (cmd_i.esc) begin
      case (phase_q)
        upqe_pkg::PhLead: begin
          byte_d = upqe_pkg::ChPercent;
          last_d = 1'b0;
        end
        upqe_pkg::PhHigh: begin
          byte_d = upqe_pkg::hex_char(cmd_i.data[7:4]);
          last_d = 1'b0;
        end
        default: begin
          byte_d = upqe_pkg::hex_char(cmd_i.data[3:0]);
          last_d = 1'b1;
        end
      endcase
    end
  end

  assign cmd_pop_o = load & last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= upqe_pkg::PhLead;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= phase_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
      done_q <= last_d & cmd_i.fin;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_done_o  = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/url_path_query_escaper_core.sv =====
// top level of the url path/query escaper
// an accepted byte is written into the command queue, then into the output register
// throughput: one output byte per cycle while the output is ready and a command waits
// a plain byte yields one output byte, an escaped byte three (%xx) from the back end
// input stays ready while the 4-entry command queue has room
// reset clears section tracking, queue pointers and the output valid
`default_nettype none
module url_path_query_escaper_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // string_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,   // run_last
  output logic            m_axis_tuser_o    // [0] url_done
);

  upqe_pkg::upqe_cmd_t front_cmd, back_cmd;
  logic                front_valid, fifo_ready, back_valid, back_pop;

  upqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tlast_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (fifo_ready),
    .cmd_o       (front_cmd)
  );

  upqe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (fifo_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_pop_i   (back_pop),
    .rd_cmd_o   (back_cmd)
  );

  upqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (back_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_done_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
